FILE: sv/armt_pkg.sv
// Shared types and constants for the address region map table.
// No dependencies.
package armt_pkg;
	localparam int MaxRegions = 64;
	localparam int AddrBits = 31;
	localparam int IdBits = 31;
	localparam int IdxBits = $clog2(MaxRegions);
	localparam int CntBits = $clog2(MaxRegions + 1);

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_STORE = 2'd1;
	localparam logic [1:0] CMD_MAP = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_OVERLAP = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic is_map;
		logic inverted;
		logic was_store;
		logic [AddrBits-1:0] lo;
		logic [AddrBits-1:0] hi;
		logic [IdBits-1:0] id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [IdBits-1:0] found;
		logic was_store;
	} rsp_t;
endpackage

FILE: sv/armt_front.sv
// Front end: accepts requests, classifies them, holds a two-entry request queue.
// Depends on armt_pkg.
module armt_front import armt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] cmd,
	input  logic [AddrBits-1:0] addr_low,
	input  logic [AddrBits-1:0] addr_high,
	input  logic [IdBits-1:0] region_id,
	output logic req_valid,
	output req_t req,
	input  logic req_take
);
	req_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	req_t nreq;
	logic do_push, do_pop;

	always_comb begin
		nreq.is_map = (cmd == CMD_MAP);
		nreq.inverted = (addr_low > addr_high);
		nreq.was_store = (cmd != CMD_LOAD) && (cmd != CMD_MAP);
		nreq.lo = addr_low;
		nreq.hi = addr_high;
		nreq.id = region_id;
	end

	assign full = (cnt_q == 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_q] <= nreq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

FILE: sv/armt_back.sv
// Back end: scans the region table one entry per cycle and appends new regions.
// Depends on armt_pkg.
module armt_back import armt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_take,
	output logic rsp_valid,
	output rsp_t rsp,
	input  logic rsp_take
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [AddrBits*2+IdBits-1:0] mem [MaxRegions];
	logic [AddrBits*2+IdBits-1:0] rdata_q;
	logic [1:0] state_q;
	logic [CntBits-1:0] count_q, idx_q;
	logic rd_pend_q;
	req_t cur_q;
	logic hit_q;
	logic [IdBits-1:0] best_q;
	logic rvalid_q;
	rsp_t rsp_q;
	logic [AddrBits-1:0] e_lo, e_hi;
	logic [IdBits-1:0] e_id;
	logic match, out_free, wr_en, rsp_load;

	assign {e_lo, e_hi, e_id} = rdata_q;
	assign match = cur_q.is_map ? (e_lo <= cur_q.hi && cur_q.lo <= e_hi)
		: (e_lo <= cur_q.lo && cur_q.lo <= e_hi);
	assign out_free = !rvalid_q || rsp_take;
	assign rsp_load = (state_q == S_DONE) && out_free;
	assign req_take = (state_q == S_IDLE) && req_valid;
	assign rsp_valid = rvalid_q;
	assign rsp = rsp_q;
	assign wr_en = (state_q == S_DONE) && out_free && cur_q.is_map && !cur_q.inverted
		&& !hit_q && (count_q < CntBits'(MaxRegions));

	always_ff @(posedge clk) begin
		rdata_q <= mem[idx_q[IdxBits-1:0]];
		if (wr_en) mem[count_q[IdxBits-1:0]] <= {cur_q.lo, cur_q.hi, cur_q.id};
		if (req_take) cur_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			best_q <= '0;
			rvalid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_load) rvalid_q <= 1'b1;
			else if (rsp_take) rvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						hit_q <= 1'b0;
						best_q <= '0;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// rdata_q holds entry idx_q-1 when rd_pend_q is set
					if (rd_pend_q && match && !(cur_q.is_map && cur_q.inverted)) begin
						if (cur_q.is_map) begin
							if (!hit_q || e_id < best_q) best_q <= e_id;
							hit_q <= 1'b1;
						end else if (!hit_q) begin
							hit_q <= 1'b1;
							best_q <= e_id;
						end
					end
					if (idx_q < count_q) begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q.was_store <= cur_q.was_store;
						if (cur_q.is_map) begin
							if (cur_q.inverted) begin
								rsp_q.status <= ST_OK;
								rsp_q.found <= '0;
							end else if (hit_q) begin
								rsp_q.status <= ST_OVERLAP;
								rsp_q.found <= best_q;
							end else if (count_q >= CntBits'(MaxRegions)) begin
								rsp_q.status <= ST_FULL;
								rsp_q.found <= '0;
							end else begin
								rsp_q.status <= ST_OK;
								rsp_q.found <= '0;
								count_q <= count_q + 1'b1;
							end
						end else begin
							rsp_q.status <= hit_q ? ST_OK : ST_MISS;
							rsp_q.found <= hit_q ? best_q : '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/address_region_map_table_top.sv
// Address region map table: a request goes through the front queue, the table scan
// and the result register; the result beat then stays on the ports until popped.
// The back end takes no new request until the last result is loaded; its single-port
// table scan reads one stored entry per cycle, up to 64 entries.
// Reset (arst_n low) empties the table and both queues at once; no clearing pass.
// Depends on armt_pkg, armt_front, armt_back.
module address_region_map_table_top import armt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] cmd,
	input  logic [AddrBits-1:0] addr_low,
	input  logic [AddrBits-1:0] addr_high,
	input  logic [IdBits-1:0] region_id,
	output logic empty,
	input  logic pop,
	output logic [1:0] status,
	output logic [IdBits-1:0] found_region,
	output logic was_store
);
	// front to back request beat
	logic req_valid, req_take, rsp_valid;
	req_t req;
	rsp_t rsp;

	armt_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.addr_low(addr_low), .addr_high(addr_high), .region_id(region_id),
		.req_valid(req_valid), .req(req), .req_take(req_take)
	);

	// back end owns the table and the result register
	armt_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req(req),
		.req_take(req_take), .rsp_valid(rsp_valid), .rsp(rsp), .rsp_take(pop)
	);

	assign empty = !rsp_valid;
	assign status = rsp.status;
	assign found_region = rsp.found;
	assign was_store = rsp.was_store;
endmodule

FILE: sv/armt_checker.sv
// Port-level checker for address_region_map_table_top, bound to the top level.
// Depends on armt_pkg.
module armt_checker import armt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [1:0] status,
	input logic [IdBits-1:0] found_region,
	input logic was_store
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(found_region)))
		else $error("result changed while waiting");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> (found_region == '0))
		else $error("table full with nonzero region");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_MISS) |-> (found_region == '0))
		else $error("miss with nonzero region");
	a_map_nostore: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == ST_OVERLAP || status == ST_FULL)) |-> !was_store)
		else $error("map result flagged as store");
endmodule

bind address_region_map_table_top armt_checker u_armt_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .status(status),
	.found_region(found_region), .was_store(was_store)
);

FILE: bench/address_region_map_table_top_tb.sv
// Testbench for address_region_map_table_top: directed table of requests, then random
// map and lookup traffic; each result beat checked against a typed or predicted result.
// Depends on armt_pkg and the address_region_map_table_top RTL.
module address_region_map_table_top_tb;
	import armt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 2_000_000;
	localparam int RandomBeats = 770;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct {
		logic [1:0] cmd;
		logic [AddrBits-1:0] lo;
		logic [AddrBits-1:0] hi;
		logic [IdBits-1:0] id;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [IdBits-1:0] found;
		logic was_store;
	} outcome_t;

	// One directed row: request, plus optional hand-typed expectation.
	typedef struct {
		request_t req;
		bit typed;
		outcome_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] cmd = CMD_LOAD;
	logic [AddrBits-1:0] addr_low = '0;
	logic [AddrBits-1:0] addr_high = '0;
	logic [IdBits-1:0] region_id = '0;
	logic full, empty, was_store;
	logic [1:0] status;
	logic [IdBits-1:0] found_region;

	address_region_map_table_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.cmd(cmd), .addr_low(addr_low), .addr_high(addr_high), .region_id(region_id),
		.empty(empty), .pop(pop), .status(status),
		.found_region(found_region), .was_store(was_store)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor's copy of the region table.
	logic [AddrBits-1:0] tbl_lo [MaxRegions];
	logic [AddrBits-1:0] tbl_hi [MaxRegions];
	logic [IdBits-1:0] tbl_id [MaxRegions];
	int tbl_count = 0;

	outcome_t pending_results [$];
	row_t rows [$];
	int mismatches = 0;
	int cycles = 0;
	bit sending_done = 1'b0;

	// Work out the result of one request and update the table.
	function automatic outcome_t resolve_request(request_t r);
		outcome_t o;
		bit hit;
		o.status = ST_MISS;
		o.found = '0;
		o.was_store = (r.cmd != CMD_LOAD) && (r.cmd != CMD_MAP);
		hit = 1'b0;
		if (r.cmd == CMD_MAP) begin
			o.was_store = 1'b0;
			o.status = ST_OK;
			if (r.lo <= r.hi) begin
				// Report the lowest id among every overlapping region.
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_lo[i] <= r.hi && r.lo <= tbl_hi[i]) begin
						if (!hit || tbl_id[i] < o.found)
							o.found = tbl_id[i];
						hit = 1'b1;
					end
				end
				if (hit)
					o.status = ST_OVERLAP;
				else if (tbl_count >= MaxRegions)
					o.status = ST_FULL;
				else begin
					tbl_lo[tbl_count] = r.lo;
					tbl_hi[tbl_count] = r.hi;
					tbl_id[tbl_count] = r.id;
					tbl_count++;
				end
			end
		end else begin
			// Lookups take the first entry in table order that holds the address.
			for (int i = 0; i < tbl_count; i++) begin
				if (!hit && tbl_lo[i] <= r.lo && r.lo <= tbl_hi[i]) begin
					o.status = ST_OK;
					o.found = tbl_id[i];
					hit = 1'b1;
				end
			end
		end
		return o;
	endfunction

	// Present one beat and hold it until accepted; drop push only when a gap is drawn.
	task automatic send_request(request_t r, bit typed, outcome_t want);
		outcome_t o;
		int gap;
		gap = $urandom_range(0, 11);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		o = resolve_request(r);
		if (typed && (o.status != want.status || o.found != want.found ||
			o.was_store != want.was_store)) begin
			// The hand-typed row trumps the predictor; flag the disagreement.
			mismatches++;
			if (mismatches <= 10)
				$display("directed row disagrees: typed %0d/%0h/%0b predicted %0d/%0h/%0b",
					want.status, want.found, want.was_store,
					o.status, o.found, o.was_store);
		end
		pending_results.insert(pending_results.size(), typed ? want : o);
		push <= 1'b1;
		cmd <= r.cmd;
		addr_low <= r.lo;
		addr_high <= r.hi;
		region_id <= r.id;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	function automatic request_t make_req(logic [1:0] c, logic [AddrBits-1:0] lo,
		logic [AddrBits-1:0] hi, logic [IdBits-1:0] id);
		request_t r;
		r.cmd = c;
		r.lo = lo;
		r.hi = hi;
		r.id = id;
		return r;
	endfunction

	function automatic outcome_t make_out(logic [1:0] s, logic [IdBits-1:0] f, logic w);
		outcome_t o;
		o.status = s;
		o.found = f;
		o.was_store = w;
		return o;
	endfunction

	// Append one directed row to the table.
	function automatic void add_row(request_t r, bit typed, outcome_t want);
		row_t w;
		w.req = r;
		w.typed = typed;
		w.want = want;
		rows.insert(rows.size(), w);
	endfunction

	// Random address: mostly a small window so ranges collide, sometimes the full span.
	function automatic logic [AddrBits-1:0] pick_addr();
		case ($urandom_range(0, 3))
			0: return AddrBits'($urandom());
			1: return AddrBits'({AddrBits{1'b1}} - $urandom_range(0, 4000));
			default: return AddrBits'($urandom_range(0, 4000));
		endcase
	endfunction

	// Sender: directed rows, a fill to the limit, then random traffic on the full table.
	initial begin
		request_t r;
		outcome_t none;
		logic [AddrBits-1:0] a;
		logic [1:0] c;
		logic [AddrBits-1:0] top;
		none = make_out(ST_OK, '0, 1'b0);
		top = {AddrBits{1'b1}};
		// After reset every lookup misses; unused code 3 acts as a store.
		add_row(make_req(CMD_LOAD, '0, '0, '0), 1'b1, make_out(ST_MISS, '0, 1'b0));
		add_row(make_req(CMD_STORE, top, '0, '0), 1'b1, make_out(ST_MISS, '0, 1'b1));
		add_row(make_req(CMD_SPARE, top, top, top), 1'b1, make_out(ST_MISS, '0, 1'b1));
		// Inverted range stores nothing.
		add_row(make_req(CMD_MAP, top, '0, 31'd5), 1'b1, make_out(ST_OK, '0, 1'b0));
		add_row(make_req(CMD_LOAD, top, '0, '0), 1'b1, make_out(ST_MISS, '0, 1'b0));
		// Single-address regions at both extremes.
		add_row(make_req(CMD_MAP, '0, '0, top), 1'b1, make_out(ST_OK, '0, 1'b0));
		add_row(make_req(CMD_MAP, top, top, '0), 1'b1, make_out(ST_OK, '0, 1'b0));
		add_row(make_req(CMD_LOAD, '0, '0, '0), 1'b1, make_out(ST_OK, top, 1'b0));
		add_row(make_req(CMD_STORE, top, '0, '0), 1'b1, make_out(ST_OK, '0, 1'b1));
		add_row(make_req(CMD_MAP, 31'd100, 31'd200, 31'd7), 1'b0, none);
		add_row(make_req(CMD_MAP, 31'd300, 31'd400, 31'd3), 1'b0, none);
		// Overlap spanning both: lowest id wins, then the whole space hits everything.
		add_row(make_req(CMD_MAP, 31'd150, 31'd350, 31'd1), 1'b1,
			make_out(ST_OVERLAP, 31'd3, 1'b0));
		add_row(make_req(CMD_MAP, '0, top, 31'd9), 1'b1, make_out(ST_OVERLAP, '0, 1'b0));
		add_row(make_req(CMD_MAP, 31'd201, 31'd299, 31'd7), 1'b0, none);
		add_row(make_req(CMD_LOAD, 31'd200, '0, '0), 1'b0, none);
		add_row(make_req(CMD_SPARE, 31'd250, '0, '0), 1'b0, none);
		add_row(make_req(CMD_LOAD, 31'd401, '0, '0), 1'b0, none);
		#1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_request(rows[i].req, rows[i].typed, rows[i].want);
		// Fill to the limit with disjoint two-address regions, then prove table-full and overlap.
		for (int i = 0; tbl_count < MaxRegions; i++)
			send_request(make_req(CMD_MAP, AddrBits'(1000 + i * 4), AddrBits'(1001 + i * 4),
				IdBits'(i)), 1'b0, none);
		send_request(make_req(CMD_MAP, 31'd5000, 31'd5000, '0), 1'b1,
			make_out(ST_FULL, '0, 1'b0));
		send_request(make_req(CMD_MAP, 31'd1001, 31'd1005, '0), 1'b0, none);
		push <= 1'b0;
		// Hold off until every result has drained.
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int n = 0; n < RandomBeats; n++) begin
			c = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 1))
				c = CMD_MAP;
			a = pick_addr();
			r = make_req(c, a,
				AddrBits'(a + $urandom_range(0, $urandom_range(0, 1) ? 50 : 3000)),
				IdBits'($urandom()));
			if ($urandom_range(0, 15) == 0)
				r.hi = AddrBits'($urandom());
			if (c != CMD_MAP)
				r.hi = AddrBits'($urandom());
			send_request(r, 1'b0, none);
		end
		push <= 1'b0;
		sending_done = 1'b1;
	end

	// Receiver: random pop stalls, compare each beat with the oldest expectation.
	initial begin
		outcome_t want;
		int stall;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: %0d/%0h/%0b",
							status, found_region, was_store);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || found_region !== want.found ||
						was_store !== want.was_store) begin
						mismatches++;
						if (mismatches <= 10)
							$display("beat mismatch: expected %0d/%0h/%0b got %0d/%0h/%0b",
								want.status, want.found, want.was_store,
								status, found_region, was_store);
					end
				end
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				if (stall != 0) begin
					pop <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				pop <= 1'b1;
			end else if (arst_n)
				pop <= 1'b1;
		end
	end

	// End of run and watchdog.
	initial begin
		@(posedge arst_n);
		while (!(sending_done && pending_results.size() == 0) && cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			// Let any stray beat show up.
			repeat (MaxRegions + 20) @(posedge clk);
			if (mismatches == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
			$finish;
		end
	end
endmodule

FILE: files.f
sv/armt_pkg.sv
sv/armt_front.sv
sv/armt_back.sv
sv/address_region_map_table_top.sv
sv/armt_checker.sv
bench/address_region_map_table_top_tb.sv
